// ===== rtl/core/sobel_edge_magnitude_rgb_unit_assert.svh =====
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/sem_pkg.sv =====
package sem_pkg;
	localparam int unsigned DefMaxWidth = 1024;
	localparam int unsigned DefMaxHeight = 1024;
	localparam int unsigned CfgW = 11;
	localparam logic [0:0] RegWidth = 1'b0;
	localparam logic [0:0] RegHeight = 1'b1;
	localparam logic [10:0] ResetWidth = 11'd640;
	localparam logic [10:0] ResetHeight = 11'd480;
	localparam logic ActPixel = 1'b0;
	localparam logic ActDrain = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WIN,
		ST_GRAD,
		ST_SQRT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic restart;
		logic rd_line;
		logic load_win;
		logic grad;
		logic sqrt_start;
		logic sqrt_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic more;
		logic sqrt_done;
	} stat_t;
endpackage

// ===== rtl/core/sem_ram.sv =====
module sem_ram #(
	parameter int unsigned Width = 24,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/sem_ctrl.sv =====
module sem_ctrl
	import sem_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  logic  cfg_we,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		if (cfg_we) begin
			cmd.restart = 1'b1;
			state_d = ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.rd_line = 1'b1;
						state_d = ST_READ;
					end
				end
				ST_READ: begin
					cmd.load_win = 1'b1;
					state_d = ST_WIN;
				end
				ST_WIN: begin
					if (stat.emit) begin
						cmd.grad = 1'b1;
						state_d = ST_GRAD;
					end else if (stat.more) begin
						cmd.rd_line = 1'b1;
						state_d = ST_READ;
					end else begin
						state_d = ST_IDLE;
					end
				end
				ST_GRAD: begin
					cmd.sqrt_start = 1'b1;
					state_d = ST_SQRT;
				end
				ST_SQRT: begin
					cmd.sqrt_step = 1'b1;
					if (stat.sqrt_done) begin
						state_d = ST_OUT;
					end
				end
				ST_OUT: begin
					out_valid = 1'b1;
					if (out_ready) begin
						cmd.out_load = 1'b1;
						state_d = ST_IDLE;
					end
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/sem_datapath.sv =====
module sem_datapath
	import sem_pkg::*;
#(
	parameter int unsigned MaxWidth = DefMaxWidth,
	parameter int unsigned MaxHeight = DefMaxHeight
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        in_take,
	input  logic        action,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [0:0]  cfg_idx,
	input  logic [10:0] cfg_data,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        frame_end
);
	localparam int unsigned AW = $clog2(MaxWidth);
	localparam int unsigned CW = $clog2(MaxWidth + 1);
	localparam int unsigned RW = $clog2(MaxHeight + 2);
	localparam int unsigned OW = $clog2(MaxWidth * MaxHeight + 1);
	localparam int unsigned EW = (CW > CfgW) ? CW : CfgW;
	localparam int unsigned FW = (RW > CfgW) ? RW : CfgW;

	logic [10:0] width_q, height_q;
	logic [CW-1:0] w_eff, col_q;
	logic [RW-1:0] h_eff, row_q;
	logic [OW-1:0] out_idx_q, total;
	logic [23:0] win_q [9];
	logic [23:0] pix_q, top_rd, mid_rd;
	logic real_q, pending_q, emit_q, emit_first_q, last_q;
	logic [2:0] guard_q;
	logic [23:0] emit_win [9];

	always_comb begin
		logic [EW-1:0] wx;
		logic [FW-1:0] hx;
		wx = EW'(width_q);
		hx = FW'(height_q);
		if (width_q == '0) w_eff = CW'(1);
		else if (wx > EW'(MaxWidth)) w_eff = CW'(MaxWidth);
		else w_eff = CW'(width_q);
		if (height_q == '0) h_eff = RW'(1);
		else if (hx > FW'(MaxHeight)) h_eff = RW'(MaxHeight);
		else h_eff = RW'(height_q);
	end

	logic [OW+CW-1:0] prod_s1;
	assign prod_s1 = (OW+CW)'(w_eff) * (OW+CW)'(h_eff);
	assign total = OW'(prod_s1);

	logic line_we;
	logic [23:0] up_wd, mid_wd;
	sem_ram #(.Width(24), .Depth(MaxWidth)) u_upper (
		.clk(clk), .we(line_we), .waddr(col_q[AW-1:0]), .wdata(up_wd),
		.raddr(col_q[AW-1:0]), .rdata(top_rd)
	);
	sem_ram #(.Width(24), .Depth(MaxWidth)) u_middle (
		.clk(clk), .we(line_we), .waddr(col_q[AW-1:0]), .wdata(mid_wd),
		.raddr(col_q[AW-1:0]), .rdata(mid_rd)
	);

	logic [23:0] top_v, mid_v, bot_v;
	logic col0, in_frame, wr_ok, emit_early, emit_late;
	assign col0 = (col_q == '0);
	assign in_frame = (row_q <= h_eff) && (col_q < CW'(MaxWidth));
	assign top_v = (row_q >= RW'(2)) ? top_rd : '0;
	assign mid_v = (row_q >= RW'(1)) ? mid_rd : '0;
	assign bot_v = real_q ? pix_q : '0;
	assign wr_ok = cmd.load_win && pending_q && in_frame;
	assign line_we = wr_ok;
	assign up_wd = mid_v;
	assign mid_wd = bot_v;
	assign emit_early = col0 && (row_q >= RW'(2));
	assign emit_late = !col0 && (row_q >= RW'(1)) && in_frame;

	logic start_ok, drain_ok;
	assign start_ok = (action == ActPixel) && (row_q < h_eff);
	assign drain_ok = !start_ok && (row_q >= h_eff) && (out_idx_q < total);

	always_ff @(posedge clk) begin
		if (in_take) begin
			pix_q <= {red_in, green_in, blue_in};
		end
		if (cmd.load_win && emit_early) begin
			for (int k = 0; k < 3; k++) begin
				emit_win[k*3]   <= win_q[k*3+1];
				emit_win[k*3+1] <= win_q[k*3+2];
				emit_win[k*3+2] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ResetWidth;
			height_q <= ResetHeight;
			col_q <= '0;
			row_q <= '0;
			out_idx_q <= '0;
			real_q <= 1'b0;
			pending_q <= 1'b0;
			emit_q <= 1'b0;
			emit_first_q <= 1'b0;
			last_q <= 1'b0;
			guard_q <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (cmd.restart) begin
			if (cfg_idx == RegWidth) width_q <= cfg_data;
			else height_q <= cfg_data;
			col_q <= '0;
			row_q <= '0;
			out_idx_q <= '0;
			pending_q <= 1'b0;
			emit_q <= 1'b0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			if (in_take) begin
				real_q <= start_ok;
				pending_q <= start_ok || drain_ok;
				guard_q <= '0;
			end
			if (cmd.rd_line) begin
				emit_q <= 1'b0;
			end
			if (cmd.load_win) begin
				guard_q <= guard_q + 3'd1;
				emit_q <= pending_q && (emit_early || emit_late);
				emit_first_q <= emit_early;
				if (pending_q) begin
					if (wr_ok) begin
						for (int k = 0; k < 3; k++) begin
							if (col0) begin
								win_q[k*3] <= '0;
								win_q[k*3+1] <= '0;
							end else begin
								win_q[k*3] <= win_q[k*3+1];
								win_q[k*3+1] <= win_q[k*3+2];
							end
						end
						win_q[2] <= top_v;
						win_q[5] <= mid_v;
						win_q[8] <= bot_v;
					end
					if (col_q + CW'(1) >= w_eff) begin
						col_q <= '0;
						row_q <= row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end
			if (cmd.grad) begin
				out_idx_q <= out_idx_q + OW'(1);
				last_q <= (out_idx_q + OW'(1)) == total;
			end
			if (cmd.out_load && last_q) begin
				col_q <= '0;
				row_q <= '0;
				out_idx_q <= '0;
				for (int i = 0; i < 9; i++) win_q[i] <= '0;
			end
		end
	end

	assign stat.emit = emit_q;
	assign stat.more = pending_q && !real_q && (guard_q < 3'd3)
		&& (row_q <= h_eff + RW'(1));

	// Gradient stage: per channel Gx and Gy, then squared sum.
	logic signed [11:0] gx_s1 [3];
	logic signed [11:0] gy_s1 [3];
	logic [21:0] sum_s2 [3];
	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic signed [11:0] p [9];
				for (int i = 0; i < 9; i++) begin
					p[i] = emit_first_q ? $signed({4'b0, emit_win[i][ch*8 +: 8]})
						: $signed({4'b0, win_q[i][ch*8 +: 8]});
				end
				gx_s1[ch] <= p[2] - p[0] + 12'sd2 * (p[5] - p[3]) + p[8] - p[6];
				gy_s1[ch] <= p[6] - p[0] + 12'sd2 * (p[7] - p[1]) + p[8] - p[2];
			end
		end
	end

	// Bit-serial square root, one result bit per cycle for all channels.
	logic [7:0] root_q [3];
	logic [3:0] bit_q;
	logic [8:0] mag [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (cmd.sqrt_start) begin
			bit_q <= 4'd8;
		end else if (cmd.sqrt_step && bit_q != '0) begin
			bit_q <= bit_q - 4'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_s2[ch] <= 22'(24'(gx_s1[ch]) * 24'(gx_s1[ch]))
					+ 22'(24'(gy_s1[ch]) * 24'(gy_s1[ch]));
				root_q[ch] <= '0;
			end
		end else if (cmd.sqrt_step && bit_q != '0) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic [7:0] t;
				t = root_q[ch] | (8'd1 << (bit_q - 4'd1));
				if ({1'b0, t} * {1'b0, t} <= {1'b0, sum_s2[ch]}) root_q[ch] <= t;
			end
		end
	end
	assign stat.sqrt_done = (bit_q == '0);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			logic [17:0] lim;
			lim = 18'(root_q[ch]) * 18'(root_q[ch]) + 18'(root_q[ch]);
			if (sum_s2[ch] > 22'd65280) mag[ch] = 9'd255;
			else if (18'(sum_s2[ch]) > lim) mag[ch] = 9'(root_q[ch]) + 9'd1;
			else mag[ch] = 9'(root_q[ch]);
		end
	end

	assign red_out = mag[2][7:0];
	assign green_out = mag[1][7:0];
	assign blue_out = mag[0][7:0];
	assign frame_end = last_q;
endmodule

// ===== rtl/core/sobel_edge_magnitude_rgb_unit.sv =====
// Sequential: one request at a time. A request that yields a result goes through the
// line read, window load, gradient and square-root states before out_valid rises; the
// next request is taken only once that result is accepted. A request without result
// goes back to idle after its last window load. The square root is bit-serial: 8 steps
// and a done check. Drain requests may step up to three positions. Reset (arst_n low)
// clears position, window and counters; line stores are not cleared.
`include "sobel_edge_magnitude_rgb_unit_assert.svh"
module sobel_edge_magnitude_rgb_unit
	import sem_pkg::*;
#(
	parameter int unsigned MaxWidth = DefMaxWidth,
	parameter int unsigned MaxHeight = DefMaxHeight
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        frame_end,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [10:0] cfg_data
);
	cmd_t cmd;
	stat_t stat;
	logic in_take;
	assign in_take = in_valid && in_ready;

	sem_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cfg_we(cfg_we),
		.stat(stat), .cmd(cmd)
	);

	sem_datapath #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_take(in_take),
		.action(action), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_end(frame_end)
	);

	`ASSERT_IMPLIES(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`ASSERT_NEXT(a_take_leaves_idle, clk, arst_n, in_take && !cfg_we, !in_ready)
endmodule

// ===== tb/tb_sobel_edge_magnitude_rgb_unit.sv =====
module tb_sobel_edge_magnitude_rgb_unit;
	import sem_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic       act;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		bit         burst;
		bit         pause;
	} pixel_req_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       fend;
	} edge_mag_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = ActPixel;
	logic [7:0]  red_in = 8'd0;
	logic [7:0]  green_in = 8'd0;
	logic [7:0]  blue_in = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic        frame_end;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_idx = RegWidth;
	logic [10:0] cfg_data = 11'd0;

	sobel_edge_magnitude_rgb_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_end(frame_end),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	pixel_req_t  pixel_q[$];
	edge_mag_t   mag_q[$];
	int unsigned err_cnt = 0;
	int unsigned req_cnt = 0;
	bit          burst_mode = 0;
	bit          pause_next = 0;

	// Predictor state.
	bit [23:0]   upper_mem [1024];
	bit [23:0]   middle_mem [1024];
	bit [23:0]   win [9];
	int unsigned col = 0;
	int unsigned row = 0;
	int unsigned emitted = 0;
	logic [10:0] reg_w = ResetWidth;
	logic [10:0] reg_h = ResetHeight;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [7:0] root_round(int unsigned s);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = 255;
		if (s > 65280)
			return 8'd255;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= s)
				lo = mid;
			else
				hi = mid - 1;
		end
		return (s > lo * lo + lo) ? lo + 1 : lo;
	endfunction

	function automatic logic [7:0] chan_mag(bit [23:0] w9 [9], int sh);
		int kx [9];
		int ky [9];
		int gx;
		int gy;
		int v;
		kx = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
		ky = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
		gx = 0;
		gy = 0;
		for (int k = 0; k < 9; k++) begin
			v = (w9[k] >> sh) & 8'hFF;
			gx += kx[k] * v;
			gy += ky[k] * v;
		end
		return root_round(int'(unsigned'(gx * gx + gy * gy)));
	endfunction

	task automatic emit_mag(bit [23:0] w9 [9]);
		int unsigned total;
		edge_mag_t m;
		total = clamp_dim(reg_w, DefMaxWidth) * clamp_dim(reg_h, DefMaxHeight);
		m.red = chan_mag(w9, 16);
		m.green = chan_mag(w9, 8);
		m.blue = chan_mag(w9, 0);
		emitted++;
		m.fend = (emitted == total);
		mag_q.push_back(m);
	endtask

	task automatic restart_frame();
		foreach (win[k])
			win[k] = '0;
		col = 0;
		row = 0;
		emitted = 0;
	endtask

	task automatic advance_pos(bit [23:0] px, bit is_pixel, output bit produced);
		int unsigned w;
		int unsigned h;
		bit [23:0] tmp [9];
		bit [23:0] top;
		bit [23:0] mid;
		bit [23:0] bot;
		w = clamp_dim(reg_w, DefMaxWidth);
		h = clamp_dim(reg_h, DefMaxHeight);
		produced = 0;
		if (col == 0 && row >= 2) begin
			for (int k = 0; k < 3; k++) begin
				tmp[k * 3] = win[k * 3 + 1];
				tmp[k * 3 + 1] = win[k * 3 + 2];
				tmp[k * 3 + 2] = '0;
			end
			emit_mag(tmp);
			produced = 1;
		end
		if (row <= h && col < DefMaxWidth) begin
			top = (row >= 2) ? upper_mem[col] : '0;
			mid = (row >= 1) ? middle_mem[col] : '0;
			bot = is_pixel ? px : '0;
			upper_mem[col] = mid;
			middle_mem[col] = bot;
			for (int k = 0; k < 3; k++) begin
				if (col == 0) begin
					win[k * 3] = '0;
					win[k * 3 + 1] = '0;
				end else begin
					win[k * 3] = win[k * 3 + 1];
					win[k * 3 + 1] = win[k * 3 + 2];
				end
			end
			win[2] = top;
			win[5] = mid;
			win[8] = bot;
			if (col != 0 && row >= 1 && !produced) begin
				emit_mag(win);
				produced = 1;
			end
		end
		col++;
		if (col >= w) begin
			col = 0;
			row++;
		end
	endtask

	task automatic predict_request(pixel_req_t it);
		int unsigned w;
		int unsigned h;
		bit produced;
		w = clamp_dim(reg_w, DefMaxWidth);
		h = clamp_dim(reg_h, DefMaxHeight);
		produced = 0;
		if (it.act == ActPixel && row < h)
			advance_pos({it.red, it.green, it.blue}, 1, produced);
		else if (row >= h && emitted < w * h)
			for (int g = 0; g < 3 && !produced && row <= h + 1; g++)
				advance_pos('0, 0, produced);
		if (produced && emitted >= w * h)
			restart_frame();
	endtask

	task automatic report(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	// Sender.
	pixel_req_t cur_req;
	int unsigned gap_left = 0;
	logic nv;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				predict_request(cur_req);
				nv = 1'b0;
				gap_left = cur_req.burst ? 0 : $urandom_range(0, 11);
			end
			if (!nv) begin
				if (gap_left > 0)
					gap_left--;
				else if (pixel_q.size() > 0 && !(pixel_q[0].pause && mag_q.size() > 0)) begin
					cur_req = pixel_q.pop_front();
					action <= cur_req.act;
					red_in <= cur_req.red;
					green_in <= cur_req.green;
					blue_in <= cur_req.blue;
					nv = 1'b1;
				end
			end
			in_valid <= nv;
		end
	end

	// Receiver.
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned rx_cnt = 0;
	bit held_once = 0;
	bit rx_fast = 0;
	edge_mag_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				rx_cnt++;
				if (mag_q.size() == 0)
					report("result arrived with no request pending");
				else begin
					want = mag_q.pop_front();
					if (red_out !== want.red)
						report($sformatf("red_out %0d, predicted %0d", red_out, want.red));
					if (green_out !== want.green)
						report($sformatf("green_out %0d, predicted %0d", green_out, want.green));
					if (blue_out !== want.blue)
						report($sformatf("blue_out %0d, predicted %0d", blue_out, want.blue));
					if (frame_end !== want.fend)
						report($sformatf("frame_end %0b, predicted %0b", frame_end, want.fend));
				end
				if (rx_cnt % 97 == 0)
					rx_fast = $urandom_range(0, 2) == 0;
				stall_left = rx_fast ? 0 : $urandom_range(0, 11);
				if (!held_once && rx_cnt >= 150 && pixel_q.size() > 20) begin
					hold_left = 400;
					held_once = 1;
				end
			end else if (hold_left > 0)
				hold_left--;
			else if (stall_left > 0)
				stall_left--;
			out_ready <= (hold_left == 0 && stall_left == 0);
		end
	end

	int unsigned quiet_cyc = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cyc = 0;
		else
			quiet_cyc++;
		if (quiet_cyc >= 4000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [7:0] chan_val();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_req(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_q.push_back('{act, r, g, b, burst_mode, pause_next});
		pause_next = 0;
		req_cnt++;
	endtask

	task automatic push_px();
		push_req(ActPixel, chan_val(), chan_val(), chan_val());
	endtask

	task automatic push_drain();
		push_req(ActDrain, chan_val(), chan_val(), chan_val());
	endtask

	task automatic write_reg(logic [0:0] idx, logic [10:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx == RegWidth)
			reg_w = val;
		else
			reg_h = val;
		restart_frame();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pixel_q.size() > 0 || in_valid || mag_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// A complete frame: pixels with stray drains, then mostly drains that release the tail.
	task automatic push_frame(int unsigned w, int unsigned h);
		int unsigned tail;
		for (int unsigned i = 0; i < w * h; i++) begin
			if ($urandom_range(0, 15) == 0)
				push_drain();
			push_px();
		end
		tail = (w * h < w + 1) ? w * h : w + 1;
		for (int unsigned i = 0; i < tail; i++) begin
			if ($urandom_range(0, 7) == 0)
				push_px();
			else
				push_drain();
		end
		repeat ($urandom_range(0, 2))
			push_drain();
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned nfr;
		int unsigned cut;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Drain while idle, then a 3x3 frame with hard edges.
		push_drain();
		wait_idle();
		write_reg(RegWidth, 11'd3);
		write_reg(RegHeight, 11'd3);
		for (int i = 0; i < 9; i++) begin
			if (i == 4)
				push_drain();
			push_req(ActPixel, (i % 2) ? 8'hFF : 8'h00, 8'(i * 28),
				(i % 3 == 0) ? 8'hFF : 8'h00);
		end
		push_drain();
		push_req(ActPixel, 8'hAA, 8'h55, 8'hAA);
		push_drain();
		push_drain();
		push_drain();
		wait_idle();

		// Zero sizes act as one.
		write_reg(RegWidth, 11'd0);
		write_reg(RegHeight, 11'd0);
		push_req(ActPixel, 8'hFF, 8'hFF, 8'hFF);
		push_drain();
		wait_idle();

		// Oversized registers clamp; frames cut short by the next write.
		write_reg(RegWidth, 11'd1);
		write_reg(RegHeight, 11'h7FF);
		repeat (6) push_px();
		wait_idle();
		write_reg(RegWidth, 11'h7FF);
		write_reg(RegHeight, 11'd2);
		repeat (4) push_px();
		push_drain();
		wait_idle();

		while (req_cnt < 1950) begin
			case ($urandom_range(0, 9))
				0: reg_w = 0;
				1: reg_w = $urandom_range(13, 40);
				2: reg_w = 1;
				default: reg_w = $urandom_range(2, 12);
			endcase
			case ($urandom_range(0, 9))
				0: h = 0;
				1: h = $urandom_range(9, 20);
				default: h = $urandom_range(1, 8);
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(RegWidth, reg_w);
				write_reg(RegHeight, h);
			end else begin
				write_reg(RegHeight, h);
				write_reg(RegWidth, reg_w);
			end
			w = clamp_dim(reg_w, DefMaxWidth);
			h = clamp_dim(reg_h, DefMaxHeight);
			burst_mode = $urandom_range(0, 3) == 0;
			nfr = $urandom_range(1, 3);
			for (int f = 0; f < nfr; f++) begin
				if (f > 0)
					pause_next = $urandom_range(0, 1);
				if ($urandom_range(0, 5) == 0) begin
					cut = $urandom_range(0, w * h - 1);
					for (int unsigned i = 0; i < cut; i++) begin
						if ($urandom_range(0, 5) == 0)
							push_drain();
						push_px();
					end
					break;
				end
				push_frame(w, h);
			end
			wait_idle();
		end
		burst_mode = 0;
		wait_idle();

		if (err_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sem_pkg.sv
rtl/core/sem_ram.sv
rtl/core/sem_ctrl.sv
rtl/core/sem_datapath.sv
rtl/core/sobel_edge_magnitude_rgb_unit.sv
tb/tb_sobel_edge_magnitude_rgb_unit.sv
